// File: sv/vnsa_pkg.sv
// ----------------------------------------------------------------------------
// vnsa_pkg
// Shared register map, configuration write bundle and reset values of the
// viewport nearest scaler address core.
// ----------------------------------------------------------------------------
package vnsa_pkg;

	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 20;
	localparam int SIZE_BITS     = 13;
	localparam int CENTER_BITS   = 20;
	localparam int ZOOM_BITS     = 16;
	localparam int ADDR_BITS     = 24;

	localparam logic [ZOOM_BITS-1:0] ZOOM_MAX = 16'hFFFF;

	// register index map
	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_MAP_WIDTH   = 3'd0,
		REG_MAP_HEIGHT  = 3'd1,
		REG_VIEW_WIDTH  = 3'd2,
		REG_VIEW_HEIGHT = 3'd3,
		REG_CENTER_X    = 3'd4,
		REG_CENTER_Y    = 3'd5,
		REG_ZOOM        = 3'd6
	} cfg_reg_t;

	// one configuration write
	typedef struct packed {
		logic                     we;
		logic [CFG_ADDR_BITS-1:0] addr;
		logic [CFG_DATA_BITS-1:0] data;
	} cfg_wr_t;

	// reset values
	localparam logic [SIZE_BITS-1:0]   RST_MAP_WIDTH   = 13'd1024;
	localparam logic [SIZE_BITS-1:0]   RST_MAP_HEIGHT  = 13'd1024;
	localparam logic [SIZE_BITS-1:0]   RST_VIEW_WIDTH  = 13'd640;
	localparam logic [SIZE_BITS-1:0]   RST_VIEW_HEIGHT = 13'd480;
	localparam logic [CENTER_BITS-1:0] RST_CENTER_X    = 20'd130944;
	localparam logic [CENTER_BITS-1:0] RST_CENTER_Y    = 20'd130944;
	localparam logic [ZOOM_BITS-1:0]   RST_ZOOM        = 16'd256;

endpackage

// File: sv/vnsa_div.sv
// ----------------------------------------------------------------------------
// vnsa_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vnsa_div #(
	parameter int W = 30
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] quo
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  sh_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  den_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [W:0]    trial;
	logic          ge;

	// next partial remainder
	assign trial = {rem_q[W-1:0], sh_q[W-1]};
	assign ge    = trial >= (W+1)'(den_q);

	// payload shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? (trial - (W+1)'(den_q)) : trial;
			sh_q  <= {sh_q[W-2:0], ge};
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1)) && !start;
			if (start) begin
				cnt_q <= CW'(W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assign done = done_q;
	assign quo  = sh_q;

endmodule

// File: sv/vnsa_frame.sv
// ----------------------------------------------------------------------------
// vnsa_frame
// Register file and per-frame setup: fit zoom, half view extents, clamped
// centers and the per-axis numerator bases, through one shared divider.
// ----------------------------------------------------------------------------
module vnsa_frame #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  vnsa_pkg::cfg_wr_t                       cfg,
	output logic                                    ready,
	output logic [COORD_BITS:0]                     map_w,
	output logic [COORD_BITS-1:0]                   map_w_m1,
	output logic [COORD_BITS-1:0]                   map_h_m1,
	output logic [COORD_BITS:0]                     view_w,
	output logic [COORD_BITS:0]                     view_h,
	output logic [COORD_BITS+FRAC_BITS+18:0]        base_x,
	output logic [COORD_BITS+FRAC_BITS+18:0]        base_y,
	output logic [FRAC_BITS+17:0]                   dvs
);
	import vnsa_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int W   = C + 2*F + 2;
	localparam int XW  = ((W > CENTER_BITS) ? W : CENTER_BITS) + 2;
	localparam int CXW = C + F + 1;
	localparam int MXW = C + F + 3;
	localparam int BW  = C + F + 19;
	localparam int EW  = (C + 1 > SIZE_BITS) ? C + 1 : SIZE_BITS;
	localparam logic [C:0] SIZE_TOP = {1'b1, {C{1'b0}}};

	typedef enum logic [7:0] {
		ST_FITX  = 8'b00000001,
		ST_FITY  = 8'b00000010,
		ST_ZOOM  = 8'b00000100,
		ST_HALFX = 8'b00001000,
		ST_HALFY = 8'b00010000,
		ST_CLAMP = 8'b00100000,
		ST_MUL   = 8'b01000000,
		ST_DONE  = 8'b10000000
	} setup_st_t;

	setup_st_t st_q;
	logic      issue_q;

	logic [SIZE_BITS-1:0]   map_width_q, map_height_q, view_width_q, view_height_q;
	logic [CENTER_BITS-1:0] center_x_q, center_y_q;
	logic [ZOOM_BITS-1:0]   zoom_q;

	logic [ZOOM_BITS-1:0] fx_q, fy_q, z_q;
	logic [W-1:0]         hx_q, hy_q;
	logic [CXW-1:0]       cx_q, cy_q;
	logic [BW-1:0]        bx_q, by_q;

	logic [C:0]     mw, mh, vw, vh;
	logic           div_start, div_done;
	logic [W-1:0]   div_num, div_den, div_quo;
	logic [ZOOM_BITS-1:0] fit_sat, z_max;
	logic signed [XW-1:0] cx_sel, cy_sel;
	logic [MXW-1:0] mx, my;

	// out-of-range sizes: zero reads as one, beyond the top as the top
	function automatic logic [C:0] size_fix(input logic [SIZE_BITS-1:0] v);
		logic [EW-1:0] e;
		e = EW'(v);
		if (e == '0) return (C+1)'(1);
		if (e > EW'(SIZE_TOP)) return SIZE_TOP;
		return e[C:0];
	endfunction

	// center clamp against the half view extent
	function automatic logic signed [XW-1:0] center_fix(
		input logic [CENTER_BITS-1:0] c,
		input logic [W-1:0]           half,
		input logic [C:0]             map
	);
		logic signed [XW-1:0] lo, hi, cc;
		lo = $signed(XW'(half));
		hi = $signed(XW'(map) << F) - lo;
		cc = $signed(XW'(c));
		if (lo > hi) return $signed(XW'(map - (C+1)'(1)) << (F - 1));
		if (cc < lo) return lo;
		if (cc > hi) return hi;
		return cc;
	endfunction

	assign mw = size_fix(map_width_q);
	assign mh = size_fix(map_height_q);
	assign vw = size_fix(view_width_q);
	assign vh = size_fix(view_height_q);

	// divider operands by setup step
	always_comb begin
		div_num = '0;
		div_den = W'(1);
		case (st_q)
			ST_FITX: begin
				div_num = (W'(vw) << F) + W'(mw) - W'(1);
				div_den = W'(mw);
			end
			ST_FITY: begin
				div_num = (W'(vh) << F) + W'(mh) - W'(1);
				div_den = W'(mh);
			end
			ST_HALFX: begin
				div_num = (W'(vw) << (2*F)) + W'(z_q);
				div_den = W'(z_q) << 1;
			end
			ST_HALFY: begin
				div_num = (W'(vh) << (2*F)) + W'(z_q);
				div_den = W'(z_q) << 1;
			end
			default: begin
				div_num = '0;
				div_den = W'(1);
			end
		endcase
	end

	assign div_start = issue_q && !cfg.we &&
		((st_q == ST_FITX) || (st_q == ST_FITY) || (st_q == ST_HALFX) || (st_q == ST_HALFY));

	vnsa_div #(.W(W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// fit zoom saturation and effective zoom
	assign fit_sat = (div_quo > W'(ZOOM_MAX)) ? ZOOM_MAX : div_quo[ZOOM_BITS-1:0];

	always_comb begin
		z_max = zoom_q;
		if (fx_q > z_max) z_max = fx_q;
		if (fy_q > z_max) z_max = fy_q;
	end

	assign cx_sel = center_fix(center_x_q, hx_q, mw);
	assign cy_sel = center_fix(center_y_q, hy_q, mh);
	assign mx = (MXW'(cx_q) << 2) + (MXW'(1) << (F + 1));
	assign my = (MXW'(cy_q) << 2) + (MXW'(1) << (F + 1));

	// setup sequencer and register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_FITX;
			issue_q       <= 1'b1;
			map_width_q   <= RST_MAP_WIDTH;
			map_height_q  <= RST_MAP_HEIGHT;
			view_width_q  <= RST_VIEW_WIDTH;
			view_height_q <= RST_VIEW_HEIGHT;
			center_x_q    <= RST_CENTER_X;
			center_y_q    <= RST_CENTER_Y;
			zoom_q        <= RST_ZOOM;
		end else if (cfg.we) begin
			st_q    <= ST_FITX;
			issue_q <= 1'b1;
			case (cfg_reg_t'(cfg.addr))
				REG_MAP_WIDTH:   map_width_q   <= cfg.data[SIZE_BITS-1:0];
				REG_MAP_HEIGHT:  map_height_q  <= cfg.data[SIZE_BITS-1:0];
				REG_VIEW_WIDTH:  view_width_q  <= cfg.data[SIZE_BITS-1:0];
				REG_VIEW_HEIGHT: view_height_q <= cfg.data[SIZE_BITS-1:0];
				REG_CENTER_X:    center_x_q    <= cfg.data[CENTER_BITS-1:0];
				REG_CENTER_Y:    center_y_q    <= cfg.data[CENTER_BITS-1:0];
				REG_ZOOM:        zoom_q        <= cfg.data[ZOOM_BITS-1:0];
				default: ;
			endcase
		end else begin
			case (st_q)
				ST_FITX, ST_FITY, ST_HALFX, ST_HALFY: begin
					if (issue_q) begin
						issue_q <= 1'b0;
					end else if (div_done) begin
						issue_q <= 1'b1;
						case (st_q)
							ST_FITX:  st_q <= ST_FITY;
							ST_FITY:  st_q <= ST_ZOOM;
							ST_HALFX: st_q <= ST_HALFY;
							default:  st_q <= ST_CLAMP;
						endcase
					end
				end
				ST_ZOOM:  st_q <= ST_HALFX;
				ST_CLAMP: st_q <= ST_MUL;
				ST_MUL:   st_q <= ST_DONE;
				ST_DONE:  st_q <= ST_DONE;
				default:  st_q <= ST_FITX;
			endcase
		end
	end

	// setup results
	always_ff @(posedge clk) begin
		if (div_done && !issue_q) begin
			if (st_q == ST_FITX)  fx_q <= fit_sat;
			if (st_q == ST_FITY)  fy_q <= fit_sat;
			if (st_q == ST_HALFX) hx_q <= div_quo;
			if (st_q == ST_HALFY) hy_q <= div_quo;
		end
		if (st_q == ST_ZOOM) z_q <= z_max;
		if (st_q == ST_CLAMP) begin
			cx_q <= cx_sel[CXW-1:0];
			cy_q <= cy_sel[CXW-1:0];
		end
		if (st_q == ST_MUL) begin
			bx_q <= mx * z_q;
			by_q <= my * z_q;
		end
	end

	assign ready    = (st_q == ST_DONE);
	assign map_w    = mw;
	assign map_w_m1 = C'(mw - (C+1)'(1));
	assign map_h_m1 = C'(mh - (C+1)'(1));
	assign view_w   = vw;
	assign view_h   = vh;
	assign base_x   = bx_q;
	assign base_y   = by_q;
	assign dvs      = {z_q, {(F+2){1'b0}}};

endmodule

// File: sv/vnsa_lane.sv
// ----------------------------------------------------------------------------
// vnsa_lane
// One axis: rounded source coordinate as a pipelined division by the frame
// divisor, one quotient bit per stage, then clamp to the map edges.
// ----------------------------------------------------------------------------
module vnsa_lane #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 8
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [COORD_BITS-1:0]            pix,
	input  logic [COORD_BITS:0]              vsize,
	input  logic [COORD_BITS-1:0]            map_m1,
	input  logic [COORD_BITS+FRAC_BITS+18:0] base,
	input  logic [FRAC_BITS+17:0]            dvs,
	output logic [COORD_BITS-1:0]            coord
);

	localparam int C   = COORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int BW  = C + F + 19;
	localparam int RMW = C + F + 18;
	localparam int NW  = ((BW > C + 2*F + 4) ? BW : C + 2*F + 4) + 1;

	logic signed [C+2:0]  ofs;
	logic signed [NW-1:0] ofs_ext;
	logic signed [NW-1:0] num_s1;
	logic [RMW-1:0]       lim;

	logic [RMW-1:0] rem_sk [C+1];
	logic [C-1:0]   quo_sk [C+1];
	logic           neg_sk [C+1];
	logic           sat_sk [C+1];
	logic [C-1:0]   coord_q;

	// numerator: frame base plus twice the signed view offset, scaled
	assign ofs     = $signed({2'b00, pix, 1'b0}) - $signed({2'b00, vsize});
	assign ofs_ext = NW'(ofs);
	assign lim     = {dvs, {C{1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= $signed(NW'(base)) + (ofs_ext <<< (2*F + 1));
		end
	end

	// sign and saturation check
	always_ff @(posedge clk) begin
		if (en) begin
			neg_sk[0] <= num_s1[NW-1];
			sat_sk[0] <= !num_s1[NW-1] && ($unsigned(num_s1) >= NW'(lim));
			rem_sk[0] <= num_s1[RMW-1:0];
			quo_sk[0] <= '0;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 1; j <= C; j++) begin : g_step
		logic [RMW-1:0] dsh;
		logic           ge;
		assign dsh = RMW'(dvs) << (C - j);
		assign ge  = rem_sk[j-1] >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[j] <= ge ? (rem_sk[j-1] - dsh) : rem_sk[j-1];
				quo_sk[j] <= {quo_sk[j-1][C-2:0], ge};
				neg_sk[j] <= neg_sk[j-1];
				sat_sk[j] <= sat_sk[j-1];
			end
		end
	end

	// edge clamp
	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_sk[C]) begin
				coord_q <= '0;
			end else if (sat_sk[C] || (quo_sk[C] > map_m1)) begin
				coord_q <= map_m1;
			end else begin
				coord_q <= quo_sk[C];
			end
		end
	end

	assign coord = coord_q;

endmodule

// File: sv/viewport_nearest_scaler_address_core.sv
// ----------------------------------------------------------------------------
// viewport_nearest_scaler_address_core
// Nearest source pixel and linear address for each view pixel under pan/zoom.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis beats carry one view pixel (view_x, view_y); m_axis beats carry
//    the clamped source column, row and linear address row*map_width+col.
//  - the cfg port writes the seven registers by index; writes must go in while
//    no beat is in flight, which the block itself does not enforce.
//  - throughput: one beat per clock, sustained while setup is done and m_axis_tready is high.
//  - pipeline: numerator register, sign and saturation check, the per-axis
//    division of one quotient bit per stage, edge clamp, then the address
//    multiply and the output register.
//  - after reset and after every register write, a setup sequence holds
//    s_axis_tready low while one shared iterative divider works out the fit
//    zoom and half view extents in four divides, followed by the centre clamp
//    and base multiply steps.
//  - when m_axis_tready is low the whole pipeline holds; the output register
//    keeps its beat and s_axis_tready stays low for as long as that beat waits.
// ----------------------------------------------------------------------------
module viewport_nearest_scaler_address_core #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [vnsa_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [vnsa_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// view_x, view_y
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// src_col, src_row, src_address
	output logic [((2*COORD_BITS+24+7)/8)*8-1:0] m_axis_tdata
);
	import vnsa_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int ODW = ((2*C + ADDR_BITS + 7) / 8) * 8;
	localparam int PW  = 2*C + 1;
	localparam int AXW = (PW > ADDR_BITS) ? PW : ADDR_BITS;

	cfg_wr_t cfg;
	logic    frame_ready;
	logic    en;
	logic    s_acc;

	logic [C:0]         map_w, view_w, view_h;
	logic [C-1:0]       map_w_m1, map_h_m1;
	logic [C+F+18:0]    base_x, base_y;
	logic [F+17:0]      dvs;
	logic [C-1:0]       col, row;

	logic [C+3:0]       vld_sk;
	logic [PW-1:0]      prod_sm;
	logic [C-1:0]       col_sm, row_sm;
	logic [AXW-1:0]     addr_full;
	logic               out_vld_q;
	logic [ODW-1:0]     out_data_q;

	assign cfg = '{we: cfg_we, addr: cfg_addr, data: cfg_wdata};

	vnsa_frame #(.COORD_BITS(C), .FRAC_BITS(F)) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.ready    (frame_ready),
		.map_w    (map_w),
		.map_w_m1 (map_w_m1),
		.map_h_m1 (map_h_m1),
		.view_w   (view_w),
		.view_h   (view_h),
		.base_x   (base_x),
		.base_y   (base_y),
		.dvs      (dvs)
	);

	// pipeline advances unless the output beat is held
	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en && frame_ready;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	vnsa_lane #(.COORD_BITS(C), .FRAC_BITS(F)) u_lane_x (
		.clk    (clk),
		.en     (en),
		.pix    (s_axis_tdata[C-1:0]),
		.vsize  (view_w),
		.map_m1 (map_w_m1),
		.base   (base_x),
		.dvs    (dvs),
		.coord  (col)
	);

	vnsa_lane #(.COORD_BITS(C), .FRAC_BITS(F)) u_lane_y (
		.clk    (clk),
		.en     (en),
		.pix    (s_axis_tdata[2*C-1:C]),
		.vsize  (view_h),
		.map_m1 (map_h_m1),
		.base   (base_y),
		.dvs    (dvs),
		.coord  (row)
	);

	// valid bits alongside the lanes and the multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk    <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_sk    <= {vld_sk[C+2:0], s_acc};
			out_vld_q <= vld_sk[C+3];
		end
	end

	// row times map width
	always_ff @(posedge clk) begin
		if (en) begin
			prod_sm <= row * map_w;
			col_sm  <= col;
			row_sm  <= row;
		end
	end

	// address add and output register
	assign addr_full = AXW'(prod_sm) + AXW'(col_sm);

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= ODW'({addr_full[ADDR_BITS-1:0], row_sm, col_sm});
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	// a register write restarts setup and blocks input
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_axis_tready)
		else $error("input taken right after a register write");

	// a stall freezes the valid pipeline
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_sk))
		else $error("valid pipeline moved during a stall");

	// an accepted beat enters the pipeline
	a_accept_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> vld_sk[0])
		else $error("accepted beat lost at pipeline entry");

	// the last stage reaches the output register
	a_reach_out: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_sk[C+3]) |=> m_axis_tvalid)
		else $error("finished beat not presented");

endmodule

// File: sim/vnsa_checker.sv
// ----------------------------------------------------------------------------
// vnsa_checker
// Scoreboard for the viewport nearest scaler address core: mirrors the
// register writes, predicts source column, row and address for every input
// beat and compares each output beat in order against the oldest prediction.
// ----------------------------------------------------------------------------
module vnsa_checker
	import vnsa_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                     s_axis_tvalid,
	input  logic                     s_axis_tready,
	input  logic [23:0]              s_axis_tdata,
	input  logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	input  logic [47:0]              m_axis_tdata,
	output int                       errors,
	output int                       pending
);

	localparam int EXP_DEPTH = 64;

	// fields from the highest bit down: address, row, column
	typedef struct packed {
		logic [ADDR_BITS-1:0] addr;
		logic [11:0]          row;
		logic [11:0]          col;
	} src_pix_t;

	// register mirror
	logic [SIZE_BITS-1:0]   map_w, map_h, view_w, view_h;
	logic [CENTER_BITS-1:0] ctr_x, ctr_y;
	logic [ZOOM_BITS-1:0]   zoom_r;

	// prediction ring
	src_pix_t exp_mem [EXP_DEPTH];
	int       wr_idx, rd_idx, fill;

	function automatic longint size_fix(longint v);
		if (v < 1) return 1;
		if (v > 4096) return 4096;
		return v;
	endfunction

	function automatic longint fit_min(longint v, longint m);
		longint q;
		q = (v * 256 + m - 1) / m;
		if (q > 65535) q = 65535;
		return q;
	endfunction

	function automatic longint center_fix(longint c, longint v, longint m, longint z);
		longint half, hi;
		half = (v * 65536 + z) / (2 * z);
		hi = m * 256 - half;
		if (half > hi) return (m - 1) * 128;
		if (c < half) return half;
		if (c > hi) return hi;
		return c;
	endfunction

	function automatic longint nearest_src(longint c, longint p, longint v, longint m,
			longint z);
		longint num, den, r;
		num = c * 2 * z + (2 * p - v) * 65536;
		den = z * 512;
		if (num >= 0) r = (2 * num + den) / (2 * den);
		else r = -((-2 * num + den) / (2 * den));
		if (r < 0) r = 0;
		if (r > m - 1) r = m - 1;
		return r;
	endfunction

	function automatic src_pix_t map_view_pixel(logic [11:0] px, logic [11:0] py);
		longint mw, mh, vw, vh, z, cx, cy, col, row;
		src_pix_t s;
		mw = size_fix(map_w);
		mh = size_fix(map_h);
		vw = size_fix(view_w);
		vh = size_fix(view_h);
		z = zoom_r;
		if (fit_min(vw, mw) > z) z = fit_min(vw, mw);
		if (fit_min(vh, mh) > z) z = fit_min(vh, mh);
		cx = center_fix(ctr_x, vw, mw, z);
		cy = center_fix(ctr_y, vh, mh, z);
		col = nearest_src(cx, px, vw, mw, z);
		row = nearest_src(cy, py, vh, mh, z);
		s.col = col[11:0];
		s.row = row[11:0];
		s.addr = 24'(row * mw + col);
		return s;
	endfunction

	// mirror writes, compare on output beats, predict on input beats
	always @(posedge clk or negedge arst_n) begin
		src_pix_t exp_s, got_s;
		int nerr;
		if (!arst_n) begin
			map_w   <= RST_MAP_WIDTH;
			map_h   <= RST_MAP_HEIGHT;
			view_w  <= RST_VIEW_WIDTH;
			view_h  <= RST_VIEW_HEIGHT;
			ctr_x   <= RST_CENTER_X;
			ctr_y   <= RST_CENTER_Y;
			zoom_r  <= RST_ZOOM;
			errors  <= 0;
			pending <= 0;
			wr_idx = 0;
			rd_idx = 0;
			fill   = 0;
		end else begin
			nerr = 0;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_addr))
					REG_MAP_WIDTH:   map_w  <= cfg_wdata[SIZE_BITS-1:0];
					REG_MAP_HEIGHT:  map_h  <= cfg_wdata[SIZE_BITS-1:0];
					REG_VIEW_WIDTH:  view_w <= cfg_wdata[SIZE_BITS-1:0];
					REG_VIEW_HEIGHT: view_h <= cfg_wdata[SIZE_BITS-1:0];
					REG_CENTER_X:    ctr_x  <= cfg_wdata[CENTER_BITS-1:0];
					REG_CENTER_Y:    ctr_y  <= cfg_wdata[CENTER_BITS-1:0];
					REG_ZOOM:        zoom_r <= cfg_wdata[ZOOM_BITS-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_s = m_axis_tdata;
				if (fill == 0) begin
					$error("output beat with no prediction waiting: %h", m_axis_tdata);
					nerr = nerr + 1;
				end else begin
					exp_s = exp_mem[rd_idx];
					rd_idx = (rd_idx + 1) % EXP_DEPTH;
					fill = fill - 1;
					if (got_s.col !== exp_s.col) begin
						$error("src_col expected %0d actual %0d", exp_s.col, got_s.col);
						nerr = nerr + 1;
					end
					if (got_s.row !== exp_s.row) begin
						$error("src_row expected %0d actual %0d", exp_s.row, got_s.row);
						nerr = nerr + 1;
					end
					if (got_s.addr !== exp_s.addr) begin
						$error("src_address expected %0d actual %0d", exp_s.addr,
							got_s.addr);
						nerr = nerr + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (fill == EXP_DEPTH) begin
					$error("prediction ring overflow");
					nerr = nerr + 1;
				end else begin
					exp_mem[wr_idx] = map_view_pixel(s_axis_tdata[11:0], s_axis_tdata[23:12]);
					wr_idx = (wr_idx + 1) % EXP_DEPTH;
					fill = fill + 1;
				end
			end
			errors  <= errors + nerr;
			pending <= fill;
		end
	end

endmodule

// File: sim/tb_viewport_nearest_scaler_address_core.sv
// ----------------------------------------------------------------------------
// tb_viewport_nearest_scaler_address_core
// Drives view pixels in random bursts under a series of pan/zoom settings,
// with receiver stalls and one long hold-off; the checker judges each beat.
// ----------------------------------------------------------------------------
module tb_viewport_nearest_scaler_address_core;
	import vnsa_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TOTAL_ITEMS    = 1850;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [23:0]              s_axis_tdata = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [47:0]              m_axis_tdata;

	int errors, pending;
	int beats_sent = 0;
	int idle_cycles = 0;
	logic hold_off = 1'b0;

	// current settings, for shaping the coordinates
	logic [12:0] cur_vw = 13'd640, cur_vh = 13'd480;

	always #10 clk = ~clk;

	viewport_nearest_scaler_address_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	vnsa_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.errors(errors), .pending(pending)
	);

	// receiver stall pattern: always ready, mostly ready or mostly stalled, by random mode
	always @(negedge clk) begin
		int mode, cnt;
		if (cnt == 0) mode = $urandom_range(0, 2);
		cnt = (cnt + 1) % 64;
		if (hold_off) m_axis_tready = 1'b0;
		else if (mode == 0) m_axis_tready = 1'b1;
		else if (mode == 1) m_axis_tready = ($urandom_range(0, 9) < 7);
		else m_axis_tready = ($urandom_range(0, 9) < 3);
	end

	// long hold-off while the sender keeps offering beats
	initial begin
		wait (beats_sent >= 400);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (400) @(negedge clk);
		hold_off = 1'b0;
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we
				|| !arst_n)
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_pixel(logic [11:0] px, logic [11:0] py);
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {py, px};
		do @(posedge clk); while (!s_axis_tready);
		beats_sent++;
	endtask

	task automatic gap_cycles(int n);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// wait until every prediction is matched, then let the pipeline settle
	task automatic drain();
		gap_cycles(0);
		while (pending != 0) @(negedge clk);
		repeat (25) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_BITS-1:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = r;
		cfg_wdata = v;
	endtask

	task automatic load_view(logic [12:0] mw, logic [12:0] mh, logic [12:0] vw,
			logic [12:0] vh, logic [19:0] cx, logic [19:0] cy, logic [15:0] z);
		drain();
		write_reg(REG_MAP_WIDTH, 20'(mw));
		write_reg(REG_MAP_HEIGHT, 20'(mh));
		write_reg(REG_VIEW_WIDTH, 20'(vw));
		write_reg(REG_VIEW_HEIGHT, 20'(vh));
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_ZOOM, 20'(z));
		@(negedge clk);
		cfg_we = 1'b0;
		cur_vw = vw;
		cur_vh = vh;
	endtask

	function automatic logic [12:0] rand_size();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0) return 13'd0;
		if (k == 1) return 13'($urandom_range(4097, 8191));
		if (k < 8) return 13'($urandom_range(1, 64));
		return 13'($urandom_range(1, 4096));
	endfunction

	function automatic logic [11:0] rand_coord(logic [12:0] v);
		int lim;
		lim = (v == 0) ? 1 : ((v > 4096) ? 4096 : int'(v));
		if ($urandom_range(0, 9) < 7) return 12'($urandom_range(0, lim - 1));
		return 12'($urandom_range(0, 4095));
	endfunction

	// corners of the coordinate range and centre pixel of the current view
	task automatic send_corners();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'hFFF, 12'hFFF);
		send_pixel(12'd0, 12'hFFF);
		send_pixel(12'hFFF, 12'd0);
		send_pixel(12'(cur_vw / 2), 12'(cur_vh / 2));
	endtask

	task automatic send_random(int n);
		int left, burst;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 30);
			if (burst > left) burst = left;
			repeat (burst) send_pixel(rand_coord(cur_vw), rand_coord(cur_vh));
			left -= burst;
			if ($urandom_range(0, 9) < 7) gap_cycles($urandom_range(1, 6));
		end
	endtask

	initial begin
		logic [12:0] mw, mh;
		logic [19:0] cx, cy;
		logic [15:0] z;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// reset settings
		send_corners();
		send_random(100);

		// zoom of zero with a view far larger than a one-pixel map
		load_view(13'd1, 13'd1, 13'd4096, 13'd4096, 20'd0, 20'd0, 16'd0);
		send_corners();
		// tiny view, biggest map, centre and zoom at their maximum
		load_view(13'd4096, 13'd4096, 13'd1, 13'd1, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_corners();
		// out-of-range sizes, smallest nonzero zoom
		load_view(13'd0, 13'd8191, 13'd8191, 13'd0, 20'h80000, 20'd1, 16'd1);
		send_corners();
		// view equal to map
		load_view(13'd4096, 13'd4096, 13'd4096, 13'd4096, 20'd524288, 20'd0, 16'd256);
		send_corners();

		// random settings
		while (beats_sent < TOTAL_ITEMS) begin
			mw = rand_size();
			mh = rand_size();
			if ($urandom_range(0, 1)) begin
				cx = 20'($urandom_range(0, 20'hFFFFF));
				cy = 20'($urandom_range(0, 20'hFFFFF));
			end else begin
				cx = 20'(mw * 128 + $urandom_range(0, 4095) - 2048);
				cy = 20'(mh * 128 + $urandom_range(0, 4095) - 2048);
			end
			case ($urandom_range(0, 9))
				0: z = 16'd0;
				1, 2, 3: z = 16'($urandom_range(1, 512));
				default: z = 16'($urandom_range(0, 16'hFFFF));
			endcase
			load_view(mw, mh, rand_size(), rand_size(), cx, cy, z);
			send_random(150);
		end

		drain();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
